// ----- rtl/core/stpg_pkg.sv -----
// shared constants, types, microcode codes and the quarter-wave sine table
`timescale 1ns / 1ps
`default_nettype none
package stpg_pkg;

	localparam int MAX_CHANNELS     = 8;
	localparam int SINE_TABLE_DEPTH = 1024;   // power of two

	localparam int RATE_W     = 18;
	localparam int CHAN_CNT_W = 4;
	localparam int CHAN_W     = 3;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam int QUARTER_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int INDEX_W    = QUARTER_W + 2;
	localparam int ROM_DEPTH  = SINE_TABLE_DEPTH + 1;
	localparam int ROM_ADDR_W = $clog2(ROM_DEPTH);
	localparam int DIV_CNT_W  = $clog2(INDEX_W);

	localparam int FULL_SCALE = 32767;
	localparam int KSHIFT     = $clog2(FULL_SCALE + 1);
	localparam int SCALE_S8   = 127;
	localparam int SCALE_U8   = 255;
	localparam int PROD_W     = 23;
	localparam int QEST_W     = PROD_W + 1 - KSHIFT;
	localparam int BYTE_W     = 8;

	localparam int PC_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MODE  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED      = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN  = CFG_IDX_W'(5);

	typedef enum logic [3:0] {
		OP_TAKE,
		OP_DIV,
		OP_READ,
		OP_SINE,
		OP_SCALE,
		OP_QEST,
		OP_FIX,
		OP_FMT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_TAKE,
		COND_DIV_MORE,
		COND_EMIT_PENDING
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            hold;
		cond_t            branch;
		logic [PC_W-1:0]  target;
	} ucode_t;

	typedef struct packed {
		logic in_taken;
		logic div_more;
		logic emit_pending;
	} stat_t;

	typedef logic [SAMPLE_W-1:0] quarter_table_t [0:SINE_TABLE_DEPTH];

	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint unsigned Q30_ONE     = 64'd1073741824;

	// series divisors (2n)(2n+1) for n = 1..9
	localparam longint unsigned TAYLOR_DIV [1:9] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
	};

	// round(32767*sin(pi/2*k/depth)) by an integer taylor series, elaboration only
	function automatic logic [SAMPLE_W-1:0] quarter_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		x = (Q30_HALF_PI * 64'(k)) / 64'(SINE_TABLE_DEPTH);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 9; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'(FULL_SCALE) + (Q30_ONE >> 1)) >> 30;
		if (v > 64'(FULL_SCALE)) begin
			v = 64'(FULL_SCALE);
		end
		return SAMPLE_W'(v);
	endfunction

	function automatic quarter_table_t build_quarter_table();
		quarter_table_t t;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			t[k] = quarter_entry(k);
		end
		return t;
	endfunction

	localparam quarter_table_t QUARTER_WAVE = build_quarter_table();

endpackage
`default_nettype wire

// ----- rtl/core/stpg_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module stpg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/stpg_seq.sv -----
// microcode sequencer: step counter, control store and conditional jumps
`timescale 1ns / 1ps
`default_nettype none
module stpg_seq import stpg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output op_t   op
);

	localparam logic [PC_W-1:0] PC_TAKE  = PC_W'(0);
	localparam logic [PC_W-1:0] PC_DIV   = PC_W'(1);
	localparam logic [PC_W-1:0] PC_READ  = PC_W'(2);
	localparam logic [PC_W-1:0] PC_SINE  = PC_W'(3);
	localparam logic [PC_W-1:0] PC_SCALE = PC_W'(4);
	localparam logic [PC_W-1:0] PC_QEST  = PC_W'(5);
	localparam logic [PC_W-1:0] PC_FIX   = PC_W'(6);
	localparam logic [PC_W-1:0] PC_FMT   = PC_W'(7);
	localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(8);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          uw;
	logic            hold_hit;
	logic            branch_hit;

	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			PC_TAKE:  w = '{OP_TAKE,  COND_NO_TAKE,      COND_NEVER,    PC_TAKE};
			PC_DIV:   w = '{OP_DIV,   COND_NEVER,        COND_DIV_MORE, PC_DIV};
			PC_READ:  w = '{OP_READ,  COND_NEVER,        COND_NEVER,    PC_TAKE};
			PC_SINE:  w = '{OP_SINE,  COND_NEVER,        COND_NEVER,    PC_TAKE};
			PC_SCALE: w = '{OP_SCALE, COND_NEVER,        COND_NEVER,    PC_TAKE};
			PC_QEST:  w = '{OP_QEST,  COND_NEVER,        COND_NEVER,    PC_TAKE};
			PC_FIX:   w = '{OP_FIX,   COND_NEVER,        COND_NEVER,    PC_TAKE};
			PC_FMT:   w = '{OP_FMT,   COND_NEVER,        COND_NEVER,    PC_TAKE};
			PC_EMIT:  w = '{OP_EMIT,  COND_EMIT_PENDING, COND_ALWAYS,   PC_TAKE};
			default:  w = '{OP_TAKE,  COND_NEVER,        COND_ALWAYS,   PC_TAKE};
		endcase
		return w;
	endfunction

	function automatic logic cond_hit(input cond_t c, input stat_t s);
		logic hit;
		case (c)
			COND_NEVER:        hit = 1'b0;
			COND_ALWAYS:       hit = 1'b1;
			COND_NO_TAKE:      hit = !s.in_taken;
			COND_DIV_MORE:     hit = s.div_more;
			COND_EMIT_PENDING: hit = s.emit_pending;
			default:           hit = 1'b0;
		endcase
		return hit;
	endfunction

	assign uw = ucode(pc_q);

	always_comb begin
		hold_hit = cond_hit(uw.hold, stat);
		branch_hit = cond_hit(uw.branch, stat);
		if (hold_hit) begin
			pc_next = pc_q;
		end else if (branch_hit) begin
			pc_next = uw.target;
		end else begin
			pc_next = pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_TAKE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign op = uw.op;

endmodule
`default_nettype wire

// ----- rtl/core/sine_tone_pcm_generator.sv -----
// Sine tone PCM generator top level: config registers, datapath, table ram, sequencer
//
// Usage: each transaction on the input channel (in_valid/in_ready, field restart)
// is one frame tick. The block answers with one sample per channel on the output
// channel (out_valid/out_ready, fields sample_word, channel_index, last_of_frame),
// channel 0 first, last_of_frame set on the final one. restart clears the phase
// before the frame is computed.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait; the user
// must write it only while no frame is in flight, the block does not enforce this.
// The first sample of a frame is valid once the phase index division, table read,
// scaling and formatting steps have run; the remaining channels follow one per
// cycle while out_ready is high. The phase index comes from a restoring divider
// taking one quotient bit per cycle for the 12-bit index, the rest is table read,
// scaling and formatting steps of the sequencer.
// Reset: configuration and control registers go to their defaults and the quarter-wave
// table ram is loaded one entry per cycle, all 1025 entries, with in_ready low until it is done.
// A stalled receiver holds the current sample in the output register; the block
// takes no new frame until every sample of the frame has been taken.
`timescale 1ns / 1ps
`default_nettype none
module sine_tone_pcm_generator import stpg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SAMPLE_W-1:0]   sample_word,
	output logic [CHAN_W-1:0]     channel_index,
	output logic                  last_of_frame
);

	// configuration
	logic [RATE_W-1:0]     sample_rate_q;
	logic [RATE_W-1:0]     tone_freq_q;
	logic [CHAN_CNT_W-1:0] channel_count_q;
	logic                  width16_q;
	logic                  signed_q;
	logic                  big_endian_q;

	logic [RATE_W-1:0]     rate_eff;
	logic [RATE_W-1:0]     freq_eff;
	logic [CHAN_CNT_W-1:0] chans_eff;
	logic [CHAN_W-1:0]     chan_last;

	// table load after reset
	logic [ROM_ADDR_W-1:0] fill_q;
	logic                  fill_done_q;

	// sequencer
	op_t   op;
	stat_t stat;
	logic  take;
	logic  out_take;

	// datapath
	logic [RATE_W-1:0]    phase_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RATE_W-1:0]    base_q;
	logic [RATE_W-1:0]    rem_q;
	logic [INDEX_W-1:0]   quot_q;
	logic [RATE_W:0]      psum_q;
	logic [SAMPLE_W-1:0]  s_q;
	logic [PROD_W-1:0]    prod_q;
	logic [QEST_W-1:0]    q0_q;
	logic [BYTE_W-1:0]    q8_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  sample_word_q;
	logic [CHAN_W-1:0]    channel_index_q;
	logic                 last_q;

	logic [RATE_W-1:0]     phase_start;
	logic [RATE_W:0]       div_shift;
	logic                  div_ge;
	logic [RATE_W-1:0]     div_rem_next;
	logic [1:0]            quad;
	logic [QUARTER_W-1:0]  frac;
	logic [ROM_ADDR_W-1:0] rom_raddr;
	logic [SAMPLE_W-1:0]   rom_rdata;
	logic [SAMPLE_W-1:0]   sine_val;
	logic                  psum_wrap;
	logic [RATE_W-1:0]     phase_next;
	logic                  s_neg;
	logic [SAMPLE_W-2:0]   s_mag;
	logic [SAMPLE_W-1:0]   u_off;
	logic [SAMPLE_W-1:0]   mul_a;
	logic [BYTE_W-1:0]     mul_b;
	logic [PROD_W:0]       mul_p;
	logic [PROD_W:0]       qsum;
	logic [PROD_W:0]       qfix;
	logic [PROD_W:0]       qrem;
	logic [SAMPLE_W-1:0]   code16;
	logic [SAMPLE_W-1:0]   code16_ord;
	logic [BYTE_W-1:0]     code8;
	logic [SAMPLE_W-1:0]   code_word;

	// effective settings with the out-of-range cases folded in
	always_comb begin
		rate_eff = (sample_rate_q == '0) ? RATE_W'(1) : sample_rate_q;
		freq_eff = (tone_freq_q < rate_eff) ? tone_freq_q : rate_eff - RATE_W'(1);
		if (channel_count_q == '0) begin
			chans_eff = CHAN_CNT_W'(1);
		end else if (channel_count_q > CHAN_CNT_W'(MAX_CHANNELS)) begin
			chans_eff = CHAN_CNT_W'(MAX_CHANNELS);
		end else begin
			chans_eff = channel_count_q;
		end
		chan_last = CHAN_W'(chans_eff - CHAN_CNT_W'(1));
	end

	assign in_ready = fill_done_q && (op == OP_TAKE);
	assign take = in_valid && in_ready;
	assign out_take = out_valid_q && out_ready;

	assign stat.in_taken = take;
	assign stat.div_more = (cnt_q != '0);
	assign stat.emit_pending = !(out_take && last_q);

	stpg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	stpg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (ROM_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (!fill_done_q),
		.waddr (fill_q),
		.wdata (QUARTER_WAVE[fill_q]),
		.re    (op == OP_READ),
		.raddr (rom_raddr),
		.rdata (rom_rdata)
	);

	always_comb begin
		phase_start = (phase_q < rate_eff) ? phase_q : '0;
		if (restart) begin
			phase_start = '0;
		end

		// one restoring step of the phase index division, remainder shifted up and compared with the rate
		div_shift = {rem_q, 1'b0};
		div_ge = (div_shift >= {1'b0, rate_eff});
		div_rem_next = div_ge ? RATE_W'(div_shift - {1'b0, rate_eff}) : RATE_W'(div_shift);

		quad = quot_q[INDEX_W-1 -: 2];
		frac = quot_q[QUARTER_W-1:0];
		rom_raddr = quad[0] ? ROM_ADDR_W'(SINE_TABLE_DEPTH) - ROM_ADDR_W'(frac)
			: ROM_ADDR_W'(frac);
		sine_val = quad[1] ? SAMPLE_W'(SAMPLE_W'(0) - rom_rdata) : rom_rdata;

		psum_wrap = (psum_q >= {1'b0, rate_eff});
		phase_next = psum_wrap ? RATE_W'(psum_q - {1'b0, rate_eff}) : RATE_W'(psum_q);

		s_neg = s_q[SAMPLE_W-1];
		s_mag = s_neg ? (SAMPLE_W-1)'(SAMPLE_W'(0) - s_q) : s_q[SAMPLE_W-2:0];
		u_off = s_q + SAMPLE_W'(FULL_SCALE);

		// 8-bit codes: signed |s|*127/32767, unsigned (u*255/2)/32767
		mul_a = signed_q ? SAMPLE_W'(s_mag) : u_off;
		mul_b = signed_q ? BYTE_W'(SCALE_S8) : BYTE_W'(SCALE_U8);
		mul_p = (PROD_W+1)'(mul_a) * (PROD_W+1)'(mul_b);

		// divide by 32767 through the reciprocal, then one correction
		qsum = (PROD_W+1)'(prod_q) + (PROD_W+1)'(prod_q >> KSHIFT);
		qfix = ((PROD_W+1)'(q0_q) << KSHIFT) - (PROD_W+1)'(q0_q);
		qrem = (PROD_W+1)'(prod_q) - qfix;

		if (signed_q) begin
			code16 = s_q;
		end else if (u_off == SAMPLE_W'(2 * FULL_SCALE)) begin
			code16 = u_off + SAMPLE_W'(1);
		end else begin
			code16 = u_off;
		end
		code16_ord = big_endian_q ? {code16[BYTE_W-1:0], code16[SAMPLE_W-1:BYTE_W]} : code16;
		code8 = (signed_q && s_neg) ? BYTE_W'(BYTE_W'(0) - q8_q) : q8_q;
		code_word = width16_q ? code16_ord : {BYTE_W'(0), code8};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= RATE_W'(44100);
			tone_freq_q <= RATE_W'(600);
			channel_count_q <= CHAN_CNT_W'(1);
			width16_q <= 1'b1;
			signed_q <= 1'b1;
			big_endian_q <= 1'b0;
			fill_q <= '0;
			fill_done_q <= 1'b0;
			phase_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_RATE: sample_rate_q <= cfg_data[RATE_W-1:0];
					CFG_TONE_FREQ:   tone_freq_q <= cfg_data[RATE_W-1:0];
					CFG_CHANNELS:    channel_count_q <= cfg_data[CHAN_CNT_W-1:0];
					CFG_WIDTH_MODE:  width16_q <= cfg_data[0];
					CFG_SIGNED:      signed_q <= cfg_data[0];
					CFG_BIG_ENDIAN:  big_endian_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (!fill_done_q) begin
				if (fill_q == ROM_ADDR_W'(SINE_TABLE_DEPTH)) begin
					fill_done_q <= 1'b1;
				end else begin
					fill_q <= fill_q + ROM_ADDR_W'(1);
				end
			end
			case (op)
				OP_TAKE: begin
					if (take) begin
						cnt_q <= DIV_CNT_W'(INDEX_W - 1);
					end
				end
				OP_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - DIV_CNT_W'(1);
					end
				end
				OP_SINE: phase_q <= phase_next;
				OP_FMT: out_valid_q <= 1'b1;
				OP_EMIT: begin
					if (out_take && last_q) begin
						out_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_TAKE: begin
				if (take) begin
					base_q <= phase_start;
					rem_q <= phase_start;
					quot_q <= '0;
				end
			end
			OP_DIV: begin
				rem_q <= div_rem_next;
				quot_q <= {quot_q[INDEX_W-2:0], div_ge};
			end
			OP_READ: psum_q <= (RATE_W+1)'(base_q) + (RATE_W+1)'(freq_eff);
			OP_SINE: s_q <= sine_val;
			OP_SCALE: prod_q <= signed_q ? PROD_W'(mul_p) : mul_p[PROD_W:1];
			OP_QEST: q0_q <= QEST_W'(qsum >> KSHIFT);
			OP_FIX: begin
				q8_q <= BYTE_W'(q0_q + QEST_W'(qrem >= (PROD_W+1)'(FULL_SCALE)));
			end
			OP_FMT: begin
				sample_word_q <= code_word;
				channel_index_q <= '0;
				last_q <= (chan_last == '0);
			end
			OP_EMIT: begin
				if (out_take && !last_q) begin
					channel_index_q <= channel_index_q + CHAN_W'(1);
					last_q <= ((channel_index_q + CHAN_W'(1)) == chan_last);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample_word = sample_word_q;
	assign channel_index = channel_index_q;
	assign last_of_frame = last_q;

endmodule
`default_nettype wire

// ----- rtl/core/stpg_checker.sv -----
// port-level checks on the tone generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module stpg_checker import stpg_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [SAMPLE_W-1:0] sample_word,
	input wire logic [CHAN_W-1:0]   channel_index,
	input wire logic                last_of_frame
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_word)
			&& $stable(channel_index) && $stable(last_of_frame))
		else $error("stalled output changed");

	// one frame at a time
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second frame taken while busy");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while samples pending");

	// channels of a frame come back to back in order with the same code
	a_chan_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_frame |=> out_valid
			&& channel_index == CHAN_W'($past(channel_index) + CHAN_W'(1))
			&& sample_word == $past(sample_word))
		else $error("channel sequence broken");

endmodule

bind sine_tone_pcm_generator stpg_checker u_stpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.sample_word   (sample_word),
	.channel_index (channel_index),
	.last_of_frame (last_of_frame)
);
`default_nettype wire
